// ===== rtl/bqm_pkg.sv =====
// ----------------------------------------------------------------------------
// bqm_pkg
// Shared types, constants and saturating helpers for the block-quote
// marker scanner.
// ----------------------------------------------------------------------------
package bqm_pkg;

  // field widths
  localparam int CHAR_W   = 8;
  localparam int SCOL_W   = 13;
  localparam int OFF_W    = 2;
  localparam int DEPTH_W  = 8;
  localparam int CNT_W    = 13;
  localparam int COL_W    = 15;
  localparam int IND_W    = 2;

  // limits
  localparam int LINE_MAX  = 4096;
  localparam int COL_MAX   = 32767;
  localparam int DEPTH_MAX = 255;

  // characters of interest
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'd62;

  // queue between classifier and scan engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // character class
  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_TAB   = 2'd1,
    CLS_SPACE = 2'd2,
    CLS_QUOTE = 2'd3
  } char_cls_t;

  // classified item handed from front to back
  typedef struct packed {
    char_cls_t           cls;
    logic                first;
    logic                last;
    logic                empty;
    logic [SCOL_W-1:0]   start_column;
    logic [OFF_W-1:0]    start_offset;
    logic [DEPTH_W-1:0]  start_depth;
  } tok_t;

  // column add with saturation, step is at most 4
  function automatic logic [COL_W-1:0] col_add(input logic [COL_W-1:0] col,
                                               input logic [2:0] step);
    logic [COL_W:0] sum;
    sum = {1'b0, col} + {{(COL_W-2){1'b0}}, step};
    if (sum > (COL_W+1)'(COL_MAX)) begin
      col_add = COL_W'(COL_MAX);
    end else begin
      col_add = sum[COL_W-1:0];
    end
  endfunction

  // consumed count increment, saturates at the line limit
  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] cnt);
    if (cnt >= CNT_W'(LINE_MAX)) begin
      cnt_inc = CNT_W'(LINE_MAX);
    end else begin
      cnt_inc = cnt + CNT_W'(1);
    end
  endfunction

  // depth increment, saturates at the top code
  function automatic logic [DEPTH_W-1:0] depth_inc(input logic [DEPTH_W-1:0] d);
    if (d == DEPTH_W'(DEPTH_MAX)) begin
      depth_inc = d;
    end else begin
      depth_inc = d + DEPTH_W'(1);
    end
  endfunction

endpackage

// ===== rtl/bqm_front.sv =====
// ----------------------------------------------------------------------------
// bqm_front
// Accepts line characters, classifies them and queues them for the scan
// engine in a two-entry queue.
// ----------------------------------------------------------------------------
module bqm_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bqm_pkg::CHAR_W-1:0]   in_character,
  input  logic                         in_is_first,
  input  logic                         in_is_last,
  input  logic                         in_line_empty,
  input  logic [bqm_pkg::SCOL_W-1:0]   in_start_column,
  input  logic [bqm_pkg::OFF_W-1:0]    in_start_offset,
  input  logic [bqm_pkg::DEPTH_W-1:0]  in_start_depth,
  output logic                         tok_valid,
  input  logic                         tok_ready,
  output bqm_pkg::tok_t                tok
);

  bqm_pkg::tok_t                 q_r [bqm_pkg::QUEUE_DEPTH];
  logic [bqm_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [bqm_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [bqm_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  bqm_pkg::tok_t                 tok_in;
  logic                          push;
  logic                          pop;

  // character classification
  always_comb begin
    tok_in.cls = bqm_pkg::CLS_OTHER;
    if (in_character == bqm_pkg::CH_TAB) begin
      tok_in.cls = bqm_pkg::CLS_TAB;
    end else if (in_character == bqm_pkg::CH_SPACE) begin
      tok_in.cls = bqm_pkg::CLS_SPACE;
    end else if (in_character == bqm_pkg::CH_QUOTE) begin
      tok_in.cls = bqm_pkg::CLS_QUOTE;
    end
    tok_in.first        = in_is_first;
    tok_in.last         = in_is_last;
    tok_in.empty        = in_line_empty;
    tok_in.start_column = in_start_column;
    tok_in.start_offset = in_start_offset;
    tok_in.start_depth  = in_start_depth;
  end

  // queue handshakes
  assign in_ready  = (cnt_r != bqm_pkg::QCNT_W'(bqm_pkg::QUEUE_DEPTH));
  assign push      = in_valid & in_ready;
  assign tok_valid = (cnt_r != '0);
  assign pop       = tok_valid & tok_ready;
  assign tok       = q_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + bqm_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + bqm_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + bqm_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - bqm_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= tok_in;
    end
  end

endmodule

// ===== rtl/bqm_back.sv =====
// ----------------------------------------------------------------------------
// bqm_back
// Scan engine: walks classified characters, tracks column, depth, indent
// and the backup point, and holds the line result in an output register.
// ----------------------------------------------------------------------------
module bqm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tok_valid,
  output logic                         tok_ready,
  input  bqm_pkg::tok_t                tok,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_matched,
  output logic [bqm_pkg::CNT_W-1:0]    out_consumed,
  output logic [bqm_pkg::COL_W-1:0]    out_column,
  output logic [bqm_pkg::OFF_W-1:0]    out_tab_remainder,
  output logic [bqm_pkg::DEPTH_W-1:0]  out_depth,
  output logic [bqm_pkg::IND_W-1:0]    out_indent
);

  // scan state; indent is held biased by one (0 means -1)
  logic                          scan_r,      scan_nxt;
  logic [bqm_pkg::CNT_W-1:0]     cnt_r,       cnt_nxt;
  logic [bqm_pkg::COL_W-1:0]     col_r,       col_nxt;
  logic [bqm_pkg::DEPTH_W-1:0]   depth_r,     depth_nxt;
  logic [2:0]                    ind_r,       ind_nxt;
  logic [bqm_pkg::CNT_W-1:0]     sv_cnt_r,    sv_cnt_nxt;
  logic [bqm_pkg::COL_W-1:0]     sv_col_r,    sv_col_nxt;
  logic                          sv_tab_r,    sv_tab_nxt;
  logic                          await_r,     await_nxt;

  // output register
  logic                          ov_r,        ov_nxt;
  logic                          o_match_r;
  logic [bqm_pkg::CNT_W-1:0]     o_cnt_r;
  logic [bqm_pkg::COL_W-1:0]     o_col_r;
  logic [bqm_pkg::OFF_W-1:0]     o_off_r;
  logic [bqm_pkg::DEPTH_W-1:0]   o_depth_r;
  logic [bqm_pkg::IND_W-1:0]     o_ind_r;

  // result of the current step
  logic                          emit;
  logic                          e_match;
  logic [bqm_pkg::CNT_W-1:0]     e_cnt;
  logic [bqm_pkg::COL_W-1:0]     e_col;
  logic [bqm_pkg::OFF_W-1:0]     e_off;
  logic [bqm_pkg::DEPTH_W-1:0]   e_depth;
  logic [bqm_pkg::IND_W-1:0]     e_ind;

  logic                          pop;
  logic                          tab_now;
  logic [2:0]                    step;
  logic [3:0]                    ind_sum;
  logic [bqm_pkg::COL_W-1:0]     col_first;

  // take a character when the output register can hold a result
  assign tok_ready = !ov_r || out_ready;
  assign pop       = tok_valid && tok_ready;

  // per-character scan step
  always_comb begin
    scan_nxt   = scan_r;
    cnt_nxt    = cnt_r;
    col_nxt    = col_r;
    depth_nxt  = depth_r;
    ind_nxt    = ind_r;
    sv_cnt_nxt = sv_cnt_r;
    sv_col_nxt = sv_col_r;
    sv_tab_nxt = sv_tab_r;
    await_nxt  = await_r;

    emit    = 1'b0;
    e_match = 1'b1;
    e_cnt   = cnt_r;
    e_col   = col_r;
    e_off   = '0;
    e_depth = depth_r;
    e_ind   = (ind_r == 3'd0) ? '0 : bqm_pkg::IND_W'(ind_r - 3'd1);

    tab_now   = await_r ? (tok.cls == bqm_pkg::CLS_TAB) : sv_tab_r;
    step      = (tok.cls == bqm_pkg::CLS_TAB) ? 3'd4 - {1'b0, col_r[1:0]} : 3'd1;
    ind_sum   = {1'b0, ind_r} + {1'b0, step};
    col_first = bqm_pkg::COL_W'(tok.start_column) + bqm_pkg::COL_W'(tok.start_offset)
                + bqm_pkg::COL_W'(1);

    if (tok.first) begin
      // start of scan: either no marker, or the first marker
      if (tok.empty || tok.cls != bqm_pkg::CLS_QUOTE) begin
        emit     = 1'b1;
        e_match  = 1'b0;
        e_cnt    = '0;
        e_col    = bqm_pkg::COL_W'(tok.start_column);
        e_off    = tok.start_offset;
        e_depth  = tok.start_depth;
        e_ind    = '0;
        scan_nxt = 1'b0;
      end else begin
        scan_nxt   = !tok.last;
        cnt_nxt    = bqm_pkg::CNT_W'(1);
        col_nxt    = col_first;
        depth_nxt  = bqm_pkg::depth_inc(tok.start_depth);
        ind_nxt    = 3'd1;
        sv_cnt_nxt = bqm_pkg::CNT_W'(1);
        sv_col_nxt = col_first;
        sv_tab_nxt = 1'b0;
        await_nxt  = 1'b1;
        emit       = tok.last;
        e_cnt      = bqm_pkg::CNT_W'(1);
        e_col      = col_first;
        e_depth    = bqm_pkg::depth_inc(tok.start_depth);
        e_ind      = '0;
      end
    end else if (scan_r) begin
      if (tok.empty) begin
        emit     = 1'b1;
        scan_nxt = 1'b0;
      end else begin
        sv_tab_nxt = tab_now;
        await_nxt  = 1'b0;
        unique case (tok.cls)
          bqm_pkg::CLS_TAB, bqm_pkg::CLS_SPACE: begin
            if (ind_sum > 4'd4) begin
              // indent too deep: back up to just after the latest marker
              emit     = 1'b1;
              scan_nxt = 1'b0;
              e_off    = tab_now ? 2'd3 - sv_col_r[1:0] : '0;
              e_col    = bqm_pkg::col_add(sv_col_r, 3'd1);
              e_cnt    = bqm_pkg::cnt_inc(sv_cnt_r);
              e_ind    = '0;
            end else begin
              cnt_nxt  = bqm_pkg::cnt_inc(cnt_r);
              col_nxt  = bqm_pkg::col_add(col_r, step);
              ind_nxt  = ind_sum[2:0];
              emit     = tok.last;
              scan_nxt = !tok.last;
              e_cnt    = cnt_nxt;
              e_col    = col_nxt;
              e_ind    = bqm_pkg::IND_W'(ind_sum[2:0] - 3'd1);
            end
          end
          bqm_pkg::CLS_QUOTE: begin
            cnt_nxt    = bqm_pkg::cnt_inc(cnt_r);
            col_nxt    = bqm_pkg::col_add(col_r, 3'd1);
            depth_nxt  = bqm_pkg::depth_inc(depth_r);
            ind_nxt    = 3'd0;
            sv_cnt_nxt = cnt_nxt;
            sv_col_nxt = col_nxt;
            await_nxt  = 1'b1;
            emit       = tok.last;
            scan_nxt   = !tok.last;
            e_cnt      = cnt_nxt;
            e_col      = col_nxt;
            e_depth    = depth_nxt;
            e_ind      = '0;
          end
          bqm_pkg::CLS_OTHER: begin
            emit     = 1'b1;
            scan_nxt = 1'b0;
          end
          default: begin
            emit     = 1'b1;
            scan_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  // output register valid
  always_comb begin
    ov_nxt = ov_r;
    if (pop && emit) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (pop) begin
        scan_r <= scan_nxt;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      cnt_r    <= cnt_nxt;
      col_r    <= col_nxt;
      depth_r  <= depth_nxt;
      ind_r    <= ind_nxt;
      sv_cnt_r <= sv_cnt_nxt;
      sv_col_r <= sv_col_nxt;
      sv_tab_r <= sv_tab_nxt;
      await_r  <= await_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      o_match_r <= e_match;
      o_cnt_r   <= e_cnt;
      o_col_r   <= e_col;
      o_off_r   <= e_off;
      o_depth_r <= e_depth;
      o_ind_r   <= e_ind;
    end
  end

  assign out_valid         = ov_r;
  assign out_matched       = o_match_r;
  assign out_consumed      = o_cnt_r;
  assign out_column        = o_col_r;
  assign out_tab_remainder = o_off_r;
  assign out_depth         = o_depth_r;
  assign out_indent        = o_ind_r;

endmodule

// ===== rtl/block_quote_marker_scanner.sv =====
// ----------------------------------------------------------------------------
// block_quote_marker_scanner
// Scans one text line, a character per transfer, for a block-quote prefix
// and returns one result per line.
//
//   channel  direction  ports                      transfer
//   in_      input      in_valid / in_ready        one line character
//   out_     output     out_valid / out_ready      one result per line
//
// One character per cycle sustained while no result waits on out_ready; the
// result is registered when the scan engine takes the completing character.
// A two-entry queue separates the classifier from the scan engine, and the
// result sits in an output register; while a result waits on out_ready the
// scan engine halts, the queue takes at most two more characters and then
// in_ready drops.
// Reset (rst_n low, synchronous) empties the queue, drops any scan in
// progress and clears the output valid.
// ----------------------------------------------------------------------------
module block_quote_marker_scanner (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bqm_pkg::CHAR_W-1:0]   in_character,
  input  logic                         in_is_first,
  input  logic                         in_is_last,
  input  logic                         in_line_empty,
  input  logic [bqm_pkg::SCOL_W-1:0]   in_start_column,
  input  logic [bqm_pkg::OFF_W-1:0]    in_start_offset,
  input  logic [bqm_pkg::DEPTH_W-1:0]  in_start_depth,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_matched,
  output logic [bqm_pkg::CNT_W-1:0]    out_consumed,
  output logic [bqm_pkg::COL_W-1:0]    out_column,
  output logic [bqm_pkg::OFF_W-1:0]    out_tab_remainder,
  output logic [bqm_pkg::DEPTH_W-1:0]  out_depth,
  output logic [bqm_pkg::IND_W-1:0]    out_indent
);

  logic           tok_valid;
  logic           tok_ready;
  bqm_pkg::tok_t  tok;

  // classifier and queue
  bqm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_character    (in_character),
    .in_is_first     (in_is_first),
    .in_is_last      (in_is_last),
    .in_line_empty   (in_line_empty),
    .in_start_column (in_start_column),
    .in_start_offset (in_start_offset),
    .in_start_depth  (in_start_depth),
    .tok_valid       (tok_valid),
    .tok_ready       (tok_ready),
    .tok             (tok)
  );

  // scan engine and result register
  bqm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .tok_valid         (tok_valid),
    .tok_ready         (tok_ready),
    .tok               (tok),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_matched       (out_matched),
    .out_consumed      (out_consumed),
    .out_column        (out_column),
    .out_tab_remainder (out_tab_remainder),
    .out_depth         (out_depth),
    .out_indent        (out_indent)
  );

endmodule

// ===== tb/block_quote_marker_scanner_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_quote_marker_scanner_test
// Streams text lines into the block-quote marker scanner and checks every
// line result against a cycle-free predictor of the scan. Directed lines
// hit the corner cases, a long quote chain drives the depth into
// saturation, a long receiver hold-off fills the block, and random lines
// cover the rest with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module block_quote_marker_scanner_test;

  localparam int TAB_STOP     = 4;
  localparam int MAX_GAP      = 18;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 8;
  localparam int CHAIN_LEN    = 120;
  localparam int STREAM_GOAL  = 100;
  localparam int RANDOM_GOAL  = 380;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                         matched;
    logic [bqm_pkg::CNT_W-1:0]    consumed;
    logic [bqm_pkg::COL_W-1:0]    column;
    logic [bqm_pkg::OFF_W-1:0]    tab_remainder;
    logic [bqm_pkg::DEPTH_W-1:0]  depth;
    logic [bqm_pkg::IND_W-1:0]    indent;
  } quote_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  // block ports
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [bqm_pkg::CHAR_W-1:0]   in_character = '0;
  logic                         in_is_first = 1'b0;
  logic                         in_is_last = 1'b0;
  logic                         in_line_empty = 1'b0;
  logic [bqm_pkg::SCOL_W-1:0]   in_start_column = '0;
  logic [bqm_pkg::OFF_W-1:0]    in_start_offset = '0;
  logic [bqm_pkg::DEPTH_W-1:0]  in_start_depth = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         out_matched;
  logic [bqm_pkg::CNT_W-1:0]    out_consumed;
  logic [bqm_pkg::COL_W-1:0]    out_column;
  logic [bqm_pkg::OFF_W-1:0]    out_tab_remainder;
  logic [bqm_pkg::DEPTH_W-1:0]  out_depth;
  logic [bqm_pkg::IND_W-1:0]    out_indent;

  block_quote_marker_scanner DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_character      (in_character),
    .in_is_first       (in_is_first),
    .in_is_last        (in_is_last),
    .in_line_empty     (in_line_empty),
    .in_start_column   (in_start_column),
    .in_start_offset   (in_start_offset),
    .in_start_depth    (in_start_depth),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_matched       (out_matched),
    .out_consumed      (out_consumed),
    .out_column        (out_column),
    .out_tab_remainder (out_tab_remainder),
    .out_depth         (out_depth),
    .out_indent        (out_indent)
  );

  // bookkeeping
  quote_result_t pending_results[$];
  int  n_errors = 0;
  int  n_scanned = 0;
  int  n_lines_checked = 0;
  bit  calm_tx = 1'b0;
  bit  calm_rx = 1'b0;
  int  hold_len = 0;
  logic rx_hold = 1'b0;
  int  rx_wait = 0;
  int  quiet_cycles = 0;

  // scan state of the predictor
  bit          q_scanning = 1'b0;
  bit          q_saved_tab = 1'b0;
  bit          q_await_saved = 1'b0;
  int unsigned q_consumed = 0;
  int unsigned q_column = 0;
  int unsigned q_depth = 0;
  int unsigned q_offset = 0;
  int unsigned q_saved_consumed = 0;
  int unsigned q_saved_column = 0;
  int          q_indent = 0;
  int          q_saved_indent = 0;

  function automatic int unsigned col_plus(input int unsigned a, input int unsigned b);
    return (a + b > bqm_pkg::COL_MAX) ? bqm_pkg::COL_MAX : a + b;
  endfunction

  function automatic int unsigned count_plus(input int unsigned a);
    return (a >= bqm_pkg::LINE_MAX) ? bqm_pkg::LINE_MAX : a + 1;
  endfunction

  // a quote mark: one level deeper, remember the spot right after it
  function automatic void mark_quote();
    q_depth = (q_depth >= bqm_pkg::DEPTH_MAX) ? bqm_pkg::DEPTH_MAX : q_depth + 1;
    q_consumed = count_plus(q_consumed);
    q_saved_consumed = q_consumed;
    q_saved_column = q_column;
    q_saved_indent = q_indent;
    q_await_saved = 1'b1;
  endfunction

  // close the line and report where the scan stands
  function automatic quote_result_t line_result(input bit matched);
    quote_result_t r;
    r.matched = matched;
    r.consumed = bqm_pkg::CNT_W'(q_consumed);
    r.column = bqm_pkg::COL_W'(q_column);
    r.tab_remainder = bqm_pkg::OFF_W'(q_offset);
    r.depth = bqm_pkg::DEPTH_W'(q_depth);
    r.indent = bqm_pkg::IND_W'((q_indent < 0) ? 0 : q_indent);
    q_scanning = 1'b0;
    return r;
  endfunction

  // one accepted character; returns 1 when the line's result is known
  function automatic bit predict_quote(input logic [bqm_pkg::CHAR_W-1:0] ch,
                                       input logic first,
                                       input logic last, input logic empty,
                                       input logic [bqm_pkg::SCOL_W-1:0] scol,
                                       input logic [bqm_pkg::OFF_W-1:0] soff,
                                       input logic [bqm_pkg::DEPTH_W-1:0] sdep,
                                       output quote_result_t r, output bit used);
    int step;
    r = '0;
    used = first || q_scanning;
    if (first) begin
      q_consumed = 0;
      q_column = scol;
      q_offset = soff;
      q_depth = sdep;
      q_indent = 0;
      q_saved_tab = 1'b0;
      q_await_saved = 1'b0;
      if (empty || ch != bqm_pkg::CH_QUOTE) begin
        r = line_result(1'b0);
        return 1'b1;
      end
      q_column = col_plus(q_column, q_offset + 1);
      q_offset = 0;
      mark_quote();
      q_scanning = 1'b1;
      if (last) begin
        r = line_result(1'b1);
        return 1'b1;
      end
      return 1'b0;
    end
    if (!q_scanning) return 1'b0;
    if (empty) begin
      r = line_result(1'b1);
      return 1'b1;
    end
    if (q_await_saved) begin
      q_saved_tab = (ch == bqm_pkg::CH_TAB);
      q_await_saved = 1'b0;
    end
    if (ch == bqm_pkg::CH_TAB || ch == bqm_pkg::CH_SPACE) begin
      step = (ch == bqm_pkg::CH_TAB) ? TAB_STOP - int'(q_column % TAB_STOP) : 1;
      q_indent += step;
      // too much indent: back up to just after the last marker
      if (q_indent > 3) begin
        if (q_saved_tab) q_offset = TAB_STOP - (q_saved_column % TAB_STOP) - 1;
        q_column = col_plus(q_saved_column, 1);
        q_consumed = count_plus(q_saved_consumed);
        q_indent = q_saved_indent;
        r = line_result(1'b1);
        return 1'b1;
      end
      q_consumed = count_plus(q_consumed);
      q_column = col_plus(q_column, step);
    end else if (ch == bqm_pkg::CH_QUOTE) begin
      q_indent = -1;
      q_column = col_plus(q_column, 1);
      mark_quote();
    end else begin
      r = line_result(1'b1);
      return 1'b1;
    end
    if (last) begin
      r = line_result(1'b1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // offer one character and wait for its transfer
  task automatic send_item(input logic [bqm_pkg::CHAR_W-1:0] ch, input logic first,
                           input logic last, input logic empty,
                           input logic [bqm_pkg::SCOL_W-1:0] scol,
                           input logic [bqm_pkg::OFF_W-1:0] soff,
                           input logic [bqm_pkg::DEPTH_W-1:0] sdep);
    int gap;
    quote_result_t r;
    bit used;
    gap = draw_gap(calm_tx);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_character <= ch;
    in_is_first <= first;
    in_is_last <= last;
    in_line_empty <= empty;
    in_start_column <= scol;
    in_start_offset <= soff;
    in_start_depth <= sdep;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_quote(ch, first, last, empty, scol, soff, sdep, r, used))
      pending_results.push_back(r);
    if (used) n_scanned++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_line(input string s, input logic [bqm_pkg::SCOL_W-1:0] scol,
                           input logic [bqm_pkg::OFF_W-1:0] soff,
                           input logic [bqm_pkg::DEPTH_W-1:0] sdep,
                           input bit mark_last);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], i == 0, mark_last && i == s.len() - 1, 1'b0, scol, soff, sdep);
  endtask

  function automatic logic [bqm_pkg::CHAR_W-1:0] random_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return bqm_pkg::CH_SPACE;
    if (pick < 55) return bqm_pkg::CH_TAB;
    if (pick < 80) return bqm_pkg::CH_QUOTE;
    return bqm_pkg::CHAR_W'($urandom);
  endfunction

  // mostly well-formed quote prefixes, some noise and broken line ends
  task automatic send_random_line();
    logic [bqm_pkg::CHAR_W-1:0]  chars[$];
    logic [bqm_pkg::SCOL_W-1:0]  scol;
    logic [bqm_pkg::OFF_W-1:0]   soff;
    logic [bqm_pkg::DEPTH_W-1:0] sdep;
    int len;
    int ending;
    scol = ($urandom_range(0, 3) == 0) ? bqm_pkg::SCOL_W'($urandom_range(8176, 8191))
                                        : bqm_pkg::SCOL_W'($urandom);
    soff = bqm_pkg::OFF_W'($urandom);
    sdep = ($urandom_range(0, 3) == 0) ? bqm_pkg::DEPTH_W'($urandom_range(250, 255))
                                        : bqm_pkg::DEPTH_W'($urandom);
    // a line with nothing left
    if ($urandom_range(0, 29) == 0) begin
      send_item(bqm_pkg::CHAR_W'($urandom), 1'b1, 1'($urandom), 1'b1, scol, soff, sdep);
      return;
    end
    len = $urandom_range(1, 12);
    chars.push_back(($urandom_range(0, 7) == 0) ? bqm_pkg::CHAR_W'($urandom)
                                                 : bqm_pkg::CH_QUOTE);
    for (int i = 1; i < len; i++) chars.push_back(random_char());
    ending = $urandom_range(0, 19);
    for (int i = 0; i < len; i++)
      send_item(chars[i], i == 0, ending >= 4 && i == len - 1, 1'b0,
                (i == 0) ? scol : bqm_pkg::SCOL_W'($urandom),
                (i == 0) ? soff : bqm_pkg::OFF_W'($urandom),
                (i == 0) ? sdep : bqm_pkg::DEPTH_W'($urandom));
    case (ending)
      // line ends on an empty item
      0, 1: begin
        send_item(bqm_pkg::CHAR_W'($urandom), 1'b0, 1'($urandom), 1'b1, scol, soff, sdep);
      end
      // stray characters after the line
      3: begin
        repeat ($urandom_range(1, 3))
          send_item(random_char(), 1'b0, 1'($urandom), 1'b0, scol, soff, sdep);
      end
      // otherwise the next line restarts the scan or the line ended with last
      default: ;
    endcase
  endtask

  // first values of the start fields come with the first item of each line
  task automatic test_directed();
    send_item(bqm_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b1, 13'd8191, 2'd3, 8'd255);  // nothing left
    send_line("a", 13'd0, 2'd2, 8'd7, 1'b1);                      // no marker
    send_line(">", 13'd8190, 2'd3, 8'd0, 1'b1);                   // marker after partial tab
    send_line("> x", 13'd3, 2'd0, 8'd1, 1'b1);                    // stops at other char
    send_line(">\t  ", 13'd0, 2'd0, 8'd0, 1'b1);                  // backup splits a tab
    send_line(">     ", 13'd2, 2'd1, 8'd4, 1'b1);                 // backup after spaces
    send_line(">>>", 13'd10, 2'd0, 8'd254, 1'b1);                 // nesting, depth saturates
    send_line("> ", 13'd0, 2'd0, 8'd0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0, 1'b1, 13'd0, 2'd0, 8'd0);       // ended by empty item
    send_item("x", 1'b0, 1'b1, 1'b0, 13'd0, 2'd0, 8'd0);         // ignored, no scan
    send_line(">\t", 13'd5, 2'd0, 8'd0, 1'b0);
    send_line(">", 13'd1, 2'd1, 8'd9, 1'b1);                      // restart mid scan
    go_idle();
  endtask

  // one long quote chain pushes the depth to its limit
  task automatic test_saturation();
    for (int i = 0; i < CHAIN_LEN; i++)
      send_item((i % 2 == 0) ? bqm_pkg::CH_QUOTE : bqm_pkg::CH_TAB, i == 0,
                i == CHAIN_LEN - 1, 1'b0, 13'd8191, 2'd3, 8'd200);
    go_idle();
  endtask

  // receiver holds off while the sender keeps offering short lines
  task automatic test_backpressure();
    calm_tx = 1'b1;
    hold_len = HOLD_CYCLES;
    repeat (40)
      send_item(($urandom_range(0, 1) == 0) ? bqm_pkg::CH_QUOTE : bqm_pkg::CHAR_W'("a"),
                1'b1, 1'b1, 1'b0, bqm_pkg::SCOL_W'($urandom), bqm_pkg::OFF_W'($urandom),
                bqm_pkg::DEPTH_W'($urandom));
    calm_tx = 1'b0;
    go_idle();
  endtask

  // back-to-back transfers on both sides
  task automatic test_streaming();
    int goal;
    goal = n_scanned + STREAM_GOAL;
    calm_tx = 1'b1;
    calm_rx = 1'b1;
    while (n_scanned < goal) send_random_line();
    calm_tx = 1'b0;
    calm_rx = 1'b0;
    go_idle();
  endtask

  task automatic test_random_lines();
    int goal;
    goal = n_scanned + RANDOM_GOAL;
    while (n_scanned < goal) send_random_line();
    go_idle();
  endtask

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        rx_hold <= 1'b1;
        repeat (hold_len) @(posedge clk);
        rx_hold <= 1'b0;
        hold_len = 0;
      end
    end
  end

  // receiver: random wait after each result transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_wait = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) rx_wait = draw_gap(calm_rx);
      else if (rx_wait > 0) rx_wait--;
      out_ready <= (rx_wait == 0) && !rx_hold;
    end
  end

  // result check against the oldest expectation
  quote_result_t got_result;
  quote_result_t want_result;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_result = {out_matched, out_consumed, out_column, out_tab_remainder,
                    out_depth, out_indent};
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_LIMIT)
          $display("error: unexpected result m=%0d c=%0d col=%0d r=%0d d=%0d i=%0d",
                   out_matched, out_consumed, out_column, out_tab_remainder,
                   out_depth, out_indent);
      end else begin
        want_result = pending_results.pop_front();
        n_lines_checked++;
        if (got_result !== want_result) begin
          n_errors++;
          if (n_errors <= REPORT_LIMIT) begin
            $display("error: line %0d expected m=%0d c=%0d col=%0d r=%0d d=%0d i=%0d",
                     n_lines_checked, want_result.matched, want_result.consumed,
                     want_result.column, want_result.tab_remainder, want_result.depth,
                     want_result.indent);
            $display("error: line %0d actual   m=%0d c=%0d col=%0d r=%0d d=%0d i=%0d",
                     n_lines_checked, got_result.matched, got_result.consumed,
                     got_result.column, got_result.tab_remainder, got_result.depth,
                     got_result.indent);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_backpressure();
    test_streaming();
    test_random_lines();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d scanned characters, %0d line results checked, %0d mismatches",
             n_scanned, n_lines_checked, n_errors);
    $display("summary: directed corners, depth saturation, input stall, random lines");
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bqm_pkg.sv
rtl/bqm_front.sv
rtl/bqm_back.sv
rtl/block_quote_marker_scanner.sv
tb/block_quote_marker_scanner_test.sv
